FILE: src/crc_pkg.sv
// Shared types and constants of the circle raster canvas.
// No dependencies; the core, the datapath and the controller import this package.
package crc_pkg;

  // Operand, square and squared-distance widths of the Q.8 distance test
  localparam int DW = 22;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  // Operation codes of the func field
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Shape type bytes
  localparam logic [7:0] TYPE_FILLED  = 8'h43;
  localparam logic [7:0] TYPE_OUTLINE = 8'h63;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

  localparam logic [9:0] RESET_SIDE = 10'd1;
  localparam logic [7:0] RESET_BG   = 8'd32;

  // One pixel pitch in signed Q14.8
  localparam logic signed [DW-1:0] Q8_ONE = 22'sd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SETUP,
    ST_SQUARE,
    ST_LOADR,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_init;
    logic scan_issue;
    logic setup_ops;
    logic latch_sq;
    logic read_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       draw_ok;
    logic       read_ok;
    logic       scan_last;
    logic       pipe_busy;
  } stat_t;

endpackage

FILE: src/crc_chan_if.sv
// Valid/ready channel interfaces of the circle raster canvas.
// Standalone; field widths follow the item and result formats.
interface crc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [7:0]         shape_type;
  logic signed [19:0] center_x;
  logic signed [19:0] center_y;
  logic signed [19:0] radius;
  logic [7:0]         color;
  logic [8:0]         pixel_x;
  logic [8:0]         pixel_y;

  modport source (
    output valid, func, shape_type, center_x, center_y, radius, color, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, func, shape_type, center_x, center_y, radius, color, pixel_x, pixel_y,
    output ready
  );
endinterface

interface crc_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] pixel_value;

  modport source (
    output valid, status, pixel_value,
    input  ready
  );
  modport sink (
    input  valid, status, pixel_value,
    output ready
  );
endinterface

FILE: src/circle_raster_canvas_core.sv
// Top level of the circle raster canvas: controller plus datapath.
// Depends on crc_pkg, crc_chan_if, crc_ctrl and crc_datapath.
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        func, shape_type, center_x/y, radius, color, pixel_x/y
//  out_ch   out  valid/ready        status, pixel_value
//  cfg_*    in   cfg_we only        cfg_index, cfg_wdata
//
// Clear and draw scan the clamped w*h canvas, one pixel per cycle through the canvas write port.
// Reset is synchronous (rst_n low); the canvas is not cleared and holds garbage until written.
// A finished result waits in the output register; a new transaction is taken meanwhile,
// and only its own result hand-off waits for the register to empty.
module circle_raster_canvas_core import crc_pkg::*; #(
  parameter int MAX_SIDE = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  crc_in_if.sink                in_ch,
  crc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  crc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  crc_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_ch.func),
    .in_shape_type   (in_ch.shape_type),
    .in_center_x     (in_ch.center_x),
    .in_center_y     (in_ch.center_y),
    .in_radius       (in_ch.radius),
    .in_color        (in_ch.color),
    .in_pixel_x      (in_ch.pixel_x),
    .in_pixel_y      (in_ch.pixel_y),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_ch.status),
    .out_pixel_value (out_ch.pixel_value)
  );

endmodule

FILE: src/crc_datapath.sv
// Datapath: configuration registers, item capture, pixel scan counters,
// squaring pipeline, canvas memory and result register. Uses crc_pkg.
module crc_datapath import crc_pkg::*; #(
  parameter int MAX_SIDE = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]            in_func,
  input  logic [7:0]            in_shape_type,
  input  logic signed [19:0]    in_center_x,
  input  logic signed [19:0]    in_center_y,
  input  logic signed [19:0]    in_radius,
  input  logic [7:0]            in_color,
  input  logic [8:0]            in_pixel_x,
  input  logic [8:0]            in_pixel_y,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_status,
  output logic [7:0]            out_pixel_value
);

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration
  logic [9:0] cfg_width_r;
  logic [9:0] cfg_height_r;
  logic [7:0] bg_r;

  // Captured item
  logic [1:0]         func_r;
  logic [7:0]         type_r;
  logic signed [19:0] cx_r;
  logic signed [19:0] cy_r;
  logic signed [19:0] rad_r;
  logic [7:0]         color_r;
  logic [8:0]         px_r;
  logic [8:0]         py_r;

  logic [CW-1:0] last_x;
  logic [CW-1:0] last_y;
  logic [CW-1:0] x_r;
  logic [CW-1:0] y_r;

  logic signed [DW-1:0] dx_c;
  logic signed [DW-1:0] dy_c;
  logic signed [DW-1:0] rad_ext;
  logic signed [DW-1:0] inner_c;
  logic signed [DW-1:0] opa_r;
  logic signed [DW-1:0] opb_r;
  logic [PW-1:0]        sqa_r;
  logic [PW-1:0]        sqb_r;
  logic [PW-1:0]        r2_r;
  logic [PW-1:0]        inner2_r;
  logic                 inner_neg_r;
  logic [SW-1:0]        d2_c;

  logic          va_r;
  logic          vb_r;
  logic [AW-1:0] addr_c;
  logic [AW-1:0] addr_a_r;
  logic [AW-1:0] addr_b_r;
  logic [AW-1:0] raddr_c;

  logic       clear_mode;
  logic       outline;
  logic       draw_ok;
  logic       read_ok;
  logic       hit;
  logic [7:0] wdata;
  logic [7:0] rd_data_r;
  logic       err;
  logic [7:0] value;
  logic       out_status_r;
  logic [7:0] out_value_r;

  logic [7:0] canvas_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RESET_SIDE;
      cfg_height_r <= RESET_SIDE;
      bg_r         <= RESET_BG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  cfg_width_r  <= cfg_wdata;
        CFG_HEIGHT: cfg_height_r <= cfg_wdata;
        CFG_BG:     bg_r         <= cfg_wdata[7:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      type_r  <= in_shape_type;
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      rad_r   <= in_radius;
      color_r <= in_color;
      px_r    <= in_pixel_x;
      py_r    <= in_pixel_y;
    end
  end

  // Clamp the sides to 1..MAX_SIDE and keep the last index of each
  always_comb begin
    if (cfg_width_r == 10'd0) begin
      last_x = '0;
    end else if (cfg_width_r > MAX_SIDE) begin
      last_x = CW'(MAX_SIDE - 1);
    end else begin
      last_x = CW'(cfg_width_r - 10'd1);
    end
    if (cfg_height_r == 10'd0) begin
      last_y = '0;
    end else if (cfg_height_r > MAX_SIDE) begin
      last_y = CW'(MAX_SIDE - 1);
    end else begin
      last_y = CW'(cfg_height_r - 10'd1);
    end
  end

  assign clear_mode = (func_r == FUNC_CLEAR);
  assign outline    = (type_r == TYPE_OUTLINE);
  assign draw_ok    = ((type_r == TYPE_FILLED) || (type_r == TYPE_OUTLINE)) &&
                      (rad_r > 20'sd0);
  assign read_ok    = (px_r <= last_x) && (py_r <= last_y);

  // Raster scan, row by row
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      x_r <= '0;
      y_r <= '0;
    end else if (cmd.scan_issue) begin
      if (x_r == last_x) begin
        x_r <= '0;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  assign dx_c    = $signed(DW'({x_r, 8'h00})) - {{(DW-20){cx_r[19]}}, cx_r};
  assign dy_c    = $signed(DW'({y_r, 8'h00})) - {{(DW-20){cy_r[19]}}, cy_r};
  assign rad_ext = {{(DW-20){rad_r[19]}}, rad_r};
  assign inner_c = rad_ext - Q8_ONE;
  assign addr_c  = AW'(y_r) * AW'(MAX_SIDE) + AW'(x_r);
  assign raddr_c = AW'(CW'(py_r)) * AW'(MAX_SIDE) + AW'(CW'(px_r));

  // Shared squarers: radius and inner radius during setup, dx and dy in the scan
  always_ff @(posedge clk) begin
    if (cmd.setup_ops) begin
      opa_r       <= rad_ext;
      opb_r       <= inner_c;
      inner_neg_r <= inner_c[DW-1];
    end else if (cmd.scan_issue) begin
      opa_r <= dx_c;
      opb_r <= dy_c;
    end
    sqa_r    <= PW'(opa_r * opa_r);
    sqb_r    <= PW'(opb_r * opb_r);
    addr_a_r <= addr_c;
    addr_b_r <= addr_a_r;
    if (cmd.latch_sq) begin
      r2_r     <= sqa_r;
      inner2_r <= sqb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= cmd.scan_issue;
      vb_r <= va_r;
    end
  end

  assign d2_c = {1'b0, sqa_r} + {1'b0, sqb_r};

  // Clear hits every pixel; an outline drops the inner-radius disc when the inner radius is not negative
  always_comb begin
    if (clear_mode) begin
      hit = 1'b1;
    end else begin
      hit = (d2_c <= {1'b0, r2_r}) &&
            !(outline && !inner_neg_r && (d2_c <= {1'b0, inner2_r}));
    end
  end

  assign wdata = clear_mode ? bg_r : color_r;

  always_ff @(posedge clk) begin
    if (vb_r && hit) begin
      canvas_mem[addr_b_r] <= wdata;
    end
    if (cmd.read_en) begin
      rd_data_r <= canvas_mem[raddr_c];
    end
  end

  always_comb begin
    unique case (func_r)
      FUNC_CLEAR: err = 1'b0;
      FUNC_DRAW:  err = !draw_ok;
      FUNC_READ:  err = !read_ok;
      default:    err = 1'b1;
    endcase
  end

  assign value = ((func_r == FUNC_READ) && read_ok) ? rd_data_r : 8'd0;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= err;
      out_value_r  <= value;
    end
  end

  assign out_status      = out_status_r;
  assign out_pixel_value = out_value_r;

  assign stat.func      = func_r;
  assign stat.draw_ok   = draw_ok;
  assign stat.read_ok   = read_ok;
  assign stat.scan_last = (x_r == last_x) && (y_r == last_y);
  assign stat.pipe_busy = va_r | vb_r;

endmodule

FILE: src/crc_ctrl.sv
// Controller state machine: sequences capture, setup, scan, drain, read
// and result hand-off. Uses crc_pkg for state, command and status types.
module crc_ctrl import crc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat.func)
          FUNC_CLEAR: state_nxt = ST_SCAN;
          FUNC_DRAW:  state_nxt = stat.draw_ok ? ST_SETUP : ST_RESP;
          FUNC_READ:  state_nxt = stat.read_ok ? ST_READ : ST_RESP;
          default:    state_nxt = ST_RESP;
        endcase
      end
      ST_SETUP:  state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_LOADR;
      ST_LOADR:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = ST_RESP;
      end
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state_r == ST_IDLE) && in_valid;
    cmd.scan_init  = (state_r == ST_DECODE);
    cmd.setup_ops  = (state_r == ST_SETUP);
    cmd.latch_sq   = (state_r == ST_LOADR);
    cmd.scan_issue = (state_r == ST_SCAN);
    cmd.read_en    = (state_r == ST_READ);
    cmd.load_out   = (state_r == ST_RESP) && out_free;
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register reloaded while a result waits");

  a_drained_before_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) |-> !stat.pipe_busy)
    else $error("result issued with canvas writes still in flight");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result raised outside the response state");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted transaction not decoded");

endmodule
